### rtl/txrb_pkg.sv
// Shared constants, types and operation codes of the transmit ring buffer.
package txrb_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = PTR_W + 1;

  localparam int BYTE_W       = 8;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 40;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_DONE  = 2'd1,
    OP_FAIL  = 2'd2,
    OP_FETCH = 2'd3
  } op_t;

  // Store port request from the control logic.
  typedef struct packed {
    logic  wr_en;
    ptr_t  wr_addr;
    byte_t wr_data;
    logic  rd_en;
    ptr_t  rd_addr;
  } store_req_t;

endpackage

### rtl/txrb_store.sv
// Byte store of the ring: one write port, one read port with registered data.
module txrb_store (
  input  logic                clk,
  input  txrb_pkg::store_req_t req,
  output txrb_pkg::byte_t      rd_data
);
  import txrb_pkg::*;

  byte_t mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // hold read data until the next read request
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### rtl/tx_ring_buffer_dma_segmenter_core.sv
// Top level of the transmit ring buffer with DMA burst scheduling.
//
//  channel  dir  tdata (low bit up)                          tuser  tlast
//  s_*      in   data_byte[7:0], fetch_index[15:8]           op     last_of_call
//  m_*      out  accepted, burst_start, burst_index[9:2],    -      -
//                burst_length[17:10], fetched_byte[25:18],
//                busy_res[26], used_count[34:27], zero pad
//
// One transfer is taken per cycle when the output side keeps up; each result
// passes through the middle stage, which covers the registered read of the
// byte store, and then the output register. Pointers, busy and the held burst
// length update in the accept cycle, so the next item sees them at once. A
// stalled output holds its result and one more item waits in the middle stage;
// only then does s_tready drop. rst (synchronous) empties the ring and both
// stages; the store itself is not cleared.
module tx_ring_buffer_dma_segmenter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [txrb_pkg::IN_TDATA_W-1:0]     s_tdata,   // data_byte, fetch_index
  input  logic [1:0]                          s_tuser,   // op
  input  logic                                s_tlast,   // last_of_call
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // accepted, burst_start, burst_index, burst_length, fetched_byte, busy_res, used_count
  output logic [txrb_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import txrb_pkg::*;

  // ring state
  ptr_t wr_ptr, rd_ptr;
  logic busy;
  ptr_t len_held;

  // middle stage: result waiting for store read data
  logic  pend_valid;
  logic  pend_accepted, pend_start, pend_busy, pend_fetch;
  ptr_t  pend_index, pend_len;
  cnt_t  pend_used;

  logic  advance, accept;
  byte_t rd_data;
  store_req_t req;

  op_t   op;
  byte_t data_byte, fetch_index;

  // next-state of the ring
  ptr_t wr_ptr_next, rd_ptr_next, len_held_next, wr_inc, burst_len;
  logic busy_next, full, attempt, start, stored;
  cnt_t rd_sum, used_next;

  assign op          = op_t'(s_tuser);
  assign data_byte   = s_tdata[7:0];
  assign fetch_index = s_tdata[15:8];

  // drain middle stage when the output register is free or being emptied
  assign advance  = pend_valid && (!m_tvalid || m_tready);
  assign s_tready = !pend_valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    wr_inc        = (wr_ptr == ptr_t'(BUFFER_DEPTH - 1)) ? '0 : wr_ptr + ptr_t'(1);
    full          = (wr_inc == rd_ptr);
    wr_ptr_next   = wr_ptr;
    rd_ptr_next   = rd_ptr;
    busy_next     = busy;
    len_held_next = len_held;
    stored        = 1'b0;
    attempt       = 1'b0;
    rd_sum        = cnt_t'(rd_ptr) + cnt_t'(len_held);
    case (op)
      OP_WRITE: begin
        if (!full) begin
          wr_ptr_next = wr_inc;
          stored      = 1'b1;
        end
        attempt = s_tlast;
      end
      OP_DONE: begin
        // advance read side past the finished burst, wrapping
        rd_ptr_next   = (rd_sum >= cnt_t'(BUFFER_DEPTH))
                        ? ptr_t'(rd_sum - cnt_t'(BUFFER_DEPTH)) : ptr_t'(rd_sum);
        busy_next     = 1'b0;
        len_held_next = '0;
        attempt       = 1'b1;
      end
      OP_FAIL: begin
        busy_next     = 1'b0;
        len_held_next = '0;
      end
      default: ;
    endcase

    // burst covers one contiguous run: up to write side or ring end
    burst_len = (wr_ptr_next >= rd_ptr_next)
                ? wr_ptr_next - rd_ptr_next
                : ptr_t'(cnt_t'(BUFFER_DEPTH) - cnt_t'(rd_ptr_next));
    start = attempt && !busy_next && (wr_ptr_next != rd_ptr_next);
    if (start) begin
      busy_next     = 1'b1;
      len_held_next = burst_len;
    end

    used_next = (wr_ptr_next >= rd_ptr_next)
                ? cnt_t'(wr_ptr_next - rd_ptr_next)
                : cnt_t'(BUFFER_DEPTH) - cnt_t'(rd_ptr_next) + cnt_t'(wr_ptr_next);
  end

  always_comb begin
    req.wr_en   = accept && stored;
    req.wr_addr = wr_ptr;
    req.wr_data = data_byte;
    req.rd_en   = accept && (op == OP_FETCH);
    req.rd_addr = ptr_t'(fetch_index);
  end

  txrb_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      busy       <= 1'b0;
      len_held   <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        wr_ptr   <= wr_ptr_next;
        rd_ptr   <= rd_ptr_next;
        busy     <= busy_next;
        len_held <= len_held_next;
      end
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (advance) begin
        pend_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload of the middle stage
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_accepted <= (op == OP_WRITE) && stored;
      pend_start    <= start;
      pend_index    <= start ? rd_ptr_next : '0;
      pend_len      <= start ? burst_len : '0;
      pend_busy     <= busy_next;
      pend_used     <= used_next;
      pend_fetch    <= (op == OP_FETCH) && (32'(fetch_index) < BUFFER_DEPTH);
    end
  end

  // output register: pack the result, pad the top bits with zeros
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'd0, 8'(pend_used), pend_busy, (pend_fetch ? rd_data : 8'd0),
                  8'(pend_len), 8'(pend_index), pend_start, pend_accepted};
    end
  end

`ifndef SYNTHESIS
  // an idle DMA side never holds a burst length
  assert property (@(posedge clk) disable iff (rst) !busy |-> (len_held == '0))
    else $error("burst length held while not busy");

  // a started burst leaves the block busy
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tdata[1]) |-> m_tdata[26])
    else $error("burst started but busy not reported");

  // a new result only comes from a filled middle stage
  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> $past(pend_valid))
    else $error("result appeared without pending item");

  // the ring never reports its full depth in use
  assert property (@(posedge clk) disable iff (rst)
                   pend_valid |-> (pend_used < cnt_t'(BUFFER_DEPTH)))
    else $error("used count reached ring depth");
`endif

endmodule
